FILE: hdl/acb_pkg.sv
// Shared types and constants for the compare and branch ALU.
`timescale 1ns / 1ps

package acb_pkg;

    localparam int OPCODE_W = 5;
    localparam int FLAG_W   = 2;
    localparam int ERR_W    = 2;
    localparam int PSIZE_W  = 9;

    typedef enum logic [OPCODE_W-1:0] {
        OP_MOV = 5'd0,
        OP_ADD = 5'd1,
        OP_SUB = 5'd2,
        OP_MUL = 5'd3,
        OP_DIV = 5'd4,
        OP_MOD = 5'd5,
        OP_AND = 5'd6,
        OP_OR  = 5'd7,
        OP_XOR = 5'd8,
        OP_SHL = 5'd9,
        OP_SHR = 5'd10,
        OP_CMP = 5'd11,
        OP_JG  = 5'd12,
        OP_JGE = 5'd13,
        OP_JL  = 5'd14,
        OP_JLE = 5'd15,
        OP_JMP = 5'd16
    } t_opcode;

    localparam logic [FLAG_W-1:0] FLAG_EQ = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_GT = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_LT = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd2;

    localparam logic [PSIZE_W-1:0] PSIZE_RESET = 9'd256;

    localparam logic REG_PROGRAM_SIZE = 1'b0;

    typedef struct packed {
        logic             write_dest;
        logic             jump_taken;
        logic [ERR_W-1:0] error_code;
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

endpackage

FILE: hdl/acb_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module acb_divider #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_WIDTH - 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_quo, n_quo;
    logic [DATA_WIDTH-1:0] r_div, n_div;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;

    always_comb begin
        shifted = {r_rem, r_quo[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (!diff[DATA_WIDTH]) begin
                n_rem = diff[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = shifted[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: hdl/acb_exec.sv
// Combinational operations, compare and branch decision; div and mod go to the divider.
`timescale 1ns / 1ps

module acb_exec #(
    parameter int DATA_WIDTH = 8
) (
    input  logic [acb_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [DATA_WIDTH-1:0]        i_a,
    input  logic [DATA_WIDTH-1:0]        i_b,
    input  logic [acb_pkg::FLAG_W-1:0]   i_flag,
    input  logic [acb_pkg::PSIZE_W-1:0]  i_program_size,
    output logic [DATA_WIDTH-1:0]        o_value,
    output acb_pkg::t_status             o_status,
    output logic [DATA_WIDTH-1:0]        o_target,
    output logic [acb_pkg::FLAG_W-1:0]   o_flag,
    output logic                         o_divide
);

    import acb_pkg::*;

    localparam int SH_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam int CMP_W = (DATA_WIDTH > PSIZE_W) ? DATA_WIDTH : PSIZE_W;
    localparam logic [DATA_WIDTH-1:0] WIDTH_VAL = DATA_WIDTH[DATA_WIDTH-1:0];

    logic [2*DATA_WIDTH-1:0] product;
    logic                    in_range;
    logic                    take;

    always_comb begin
        product  = {{DATA_WIDTH{1'b0}}, i_a} * {{DATA_WIDTH{1'b0}}, i_b};
        in_range = CMP_W'(i_a) < CMP_W'(i_program_size);
        o_value  = '0;
        o_status = '{write_dest: 1'b0, jump_taken: 1'b0, error_code: ERR_NONE};
        o_target = '0;
        o_flag   = i_flag;
        o_divide = 1'b0;
        take     = 1'b0;
        case (i_opcode)
            OP_MOV: begin o_value = i_b;                             o_status.write_dest = 1'b1; end
            OP_ADD: begin o_value = i_a + i_b;                       o_status.write_dest = 1'b1; end
            OP_SUB: begin o_value = i_a - i_b;                       o_status.write_dest = 1'b1; end
            OP_MUL: begin o_value = product[DATA_WIDTH-1:0];         o_status.write_dest = 1'b1; end
            OP_AND: begin o_value = i_a & i_b;                       o_status.write_dest = 1'b1; end
            OP_OR:  begin o_value = i_a | i_b;                       o_status.write_dest = 1'b1; end
            OP_XOR: begin o_value = i_a ^ i_b;                       o_status.write_dest = 1'b1; end
            OP_SHL: begin
                o_value = (i_b >= WIDTH_VAL) ? '0 : (i_a << i_b[SH_W-1:0]);
                o_status.write_dest = 1'b1;
            end
            OP_SHR: begin
                o_value = (i_b >= WIDTH_VAL) ? '0 : (i_a >> i_b[SH_W-1:0]);
                o_status.write_dest = 1'b1;
            end
            OP_DIV, OP_MOD: begin
                if (i_b == '0) begin
                    o_status.error_code = ERR_DIV_ZERO;
                end else begin
                    o_divide = 1'b1;
                end
            end
            OP_CMP: begin
                o_flag = (i_a == i_b) ? FLAG_EQ : ((i_a > i_b) ? FLAG_GT : FLAG_LT);
            end
            OP_JG, OP_JGE, OP_JL, OP_JLE, OP_JMP: begin
                case (i_opcode)
                    OP_JG:   take = (i_flag == FLAG_GT);
                    OP_JGE:  take = (i_flag == FLAG_GT) || (i_flag == FLAG_EQ);
                    OP_JL:   take = (i_flag == FLAG_LT);
                    OP_JLE:  take = (i_flag == FLAG_LT) || (i_flag == FLAG_EQ);
                    default: take = 1'b1;
                endcase
                if (!in_range) begin
                    o_status.error_code = ERR_RANGE;
                end else if (take) begin
                    o_status.jump_taken = 1'b1;
                    o_target = i_a;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/alu_compare_branch_unit.sv
// Top level of the compare and branch ALU.
`timescale 1ns / 1ps

// One instruction per transaction. The input is stalled from acceptance until
// the result transaction has been taken. Most opcodes produce their result in the
// cycle after acceptance; div and mod with a non-zero divisor run through the
// restoring divider at one quotient bit per cycle, and the result is registered
// when the divider reports done. A division by zero and an out-of-range jump
// target are reported in o_error_code and leave write and jump low. The compare
// flag changes only on cmp and resets to equal. program_size lies at address 0
// and resets to 256.

module alu_compare_branch_unit #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [4:0]            i_opcode,
    input  logic [DATA_WIDTH-1:0] i_operand_a,
    input  logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DATA_WIDTH-1:0] o_result_value,
    output logic                  o_write_dest,
    output logic                  o_jump_taken,
    output logic [DATA_WIDTH-1:0] o_jump_target,
    output logic [1:0]            o_error_code,
    output logic [1:0]            o_flag_out
);

    import acb_pkg::*;

    t_state                r_state, n_state;
    logic [PSIZE_W-1:0]    r_program_size;
    logic [FLAG_W-1:0]     r_flag, n_flag;
    logic                  r_is_mod, n_is_mod;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    t_status               r_status, n_status;
    logic [DATA_WIDTH-1:0] r_target, n_target;

    logic [DATA_WIDTH-1:0] ex_value;
    t_status               ex_status;
    logic [DATA_WIDTH-1:0] ex_target;
    logic [FLAG_W-1:0]     ex_flag;
    logic                  ex_divide;
    logic                  div_start;
    logic                  div_done;
    logic [DATA_WIDTH-1:0] div_quo;
    logic [DATA_WIDTH-1:0] div_rem;
    logic                  accept;

    acb_exec #(.DATA_WIDTH(DATA_WIDTH)) u_exec (
        .i_opcode       (i_opcode),
        .i_a            (i_operand_a),
        .i_b            (i_operand_b),
        .i_flag         (r_flag),
        .i_program_size (r_program_size),
        .o_value        (ex_value),
        .o_status       (ex_status),
        .o_target       (ex_target),
        .o_flag         (ex_flag),
        .o_divide       (ex_divide)
    );

    acb_divider #(.DATA_WIDTH(DATA_WIDTH)) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_operand_a),
        .i_divisor   (i_operand_b),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign div_start = accept && ex_divide;

    always_comb begin
        n_state  = r_state;
        n_flag   = r_flag;
        n_is_mod = r_is_mod;
        n_value  = r_value;
        n_status = r_status;
        n_target = r_target;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_flag   = ex_flag;
                    n_is_mod = (i_opcode == OP_MOD);
                    n_value  = ex_value;
                    n_status = ex_status;
                    n_target = ex_target;
                    n_state  = ex_divide ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_value  = r_is_mod ? div_rem : div_quo;
                    n_status = '{write_dest: 1'b1, jump_taken: 1'b0, error_code: ERR_NONE};
                    n_target = '0;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_flag         <= FLAG_EQ;
            r_program_size <= PSIZE_RESET;
        end else begin
            r_state <= n_state;
            r_flag  <= n_flag;
            if (psel && penable && pwrite && paddr[2] == REG_PROGRAM_SIZE) begin
                r_program_size <= pwdata[PSIZE_W-1:0];
            end
        end
        r_is_mod <= n_is_mod;
        r_value  <= n_value;
        r_status <= n_status;
        r_target <= n_target;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROGRAM_SIZE) ? {{(32-PSIZE_W){1'b0}}, r_program_size}
                                                   : '0;

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = (r_state == S_DONE);
    assign o_result_value = r_value;
    assign o_write_dest   = r_status.write_dest;
    assign o_jump_taken   = r_status.jump_taken;
    assign o_jump_target  = r_target;
    assign o_error_code   = r_status.error_code;
    assign o_flag_out     = r_flag;

endmodule

FILE: hdl/acb_checker.sv
// Port-level assertions for the compare and branch ALU, bound to the top level.
`timescale 1ns / 1ps

module acb_checker #(
    parameter int DATA_WIDTH = 8
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DATA_WIDTH-1:0] o_result_value,
    input logic                  o_write_dest,
    input logic                  o_jump_taken,
    input logic [1:0]            o_error_code
);

    import acb_pkg::*;

    // one transaction in flight: no input while a result is shown
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while result pending");

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid) || o_out_valid)
        else $error("input not stalled after acceptance");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result_value)))
        else $error("stalled result changed");

    a_no_value_without_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_dest) |-> (o_result_value == '0))
        else $error("result value without write");

    a_jump_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jump_taken) |-> (o_error_code == ERR_NONE && !o_write_dest))
        else $error("jump with error or write");

endmodule

bind alu_compare_branch_unit acb_checker #(.DATA_WIDTH(DATA_WIDTH)) u_acb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value),
    .o_write_dest   (o_write_dest),
    .o_jump_taken   (o_jump_taken),
    .o_error_code   (o_error_code)
);

FILE: tb/sv/tb.sv
// Self-checking testbench for alu_compare_branch_unit: directed and random instructions.
`timescale 1ns / 1ps

module tb;
    import acb_pkg::*;

    localparam int DW           = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [2:0]          PSIZE_ADDR   = 3'(4 * REG_PROGRAM_SIZE);
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 5'd17;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 5'd31;

    typedef struct packed {
        logic [DW-1:0]     result_value;
        logic              write_dest;
        logic              jump_taken;
        logic [DW-1:0]     jump_target;
        logic [ERR_W-1:0]  error_code;
        logic [FLAG_W-1:0] flag_out;
    } t_outcome;

    class alu_scoreboard;
        logic [FLAG_W-1:0]  flag;
        logic [PSIZE_W-1:0] program_size;
        t_outcome           pending[$];
        int                 mismatches;
        int                 checked;
        int                 div_zero_seen;
        int                 range_seen;
        int                 jumps_taken;

        function new();
            flag          = FLAG_EQ;
            program_size  = PSIZE_RESET;
            mismatches    = 0;
            checked       = 0;
            div_zero_seen = 0;
            range_seen    = 0;
            jumps_taken   = 0;
        endfunction

        // Works out the outcome of one accepted instruction.
        function void note_instruction(logic [OPCODE_W-1:0] op, logic [DW-1:0] a,
                                       logic [DW-1:0] b);
            t_outcome o;
            logic     take;
            o    = '0;
            take = 1'b0;
            case (op)
                OP_MOV: begin o.result_value = b;     o.write_dest = 1'b1; end
                OP_ADD: begin o.result_value = a + b; o.write_dest = 1'b1; end
                OP_SUB: begin o.result_value = a - b; o.write_dest = 1'b1; end
                OP_MUL: begin o.result_value = a * b; o.write_dest = 1'b1; end
                OP_DIV, OP_MOD: begin
                    if (b == '0) begin
                        o.error_code = ERR_DIV_ZERO;
                    end else begin
                        o.result_value = (op == OP_DIV) ? a / b : a % b;
                        o.write_dest   = 1'b1;
                    end
                end
                OP_AND: begin o.result_value = a & b; o.write_dest = 1'b1; end
                OP_OR:  begin o.result_value = a | b; o.write_dest = 1'b1; end
                OP_XOR: begin o.result_value = a ^ b; o.write_dest = 1'b1; end
                OP_SHL: begin
                    o.result_value = (b >= DW) ? '0 : a << b;
                    o.write_dest   = 1'b1;
                end
                OP_SHR: begin
                    o.result_value = (b >= DW) ? '0 : a >> b;
                    o.write_dest   = 1'b1;
                end
                OP_CMP: begin
                    flag = (a == b) ? FLAG_EQ : ((a > b) ? FLAG_GT : FLAG_LT);
                end
                OP_JG, OP_JGE, OP_JL, OP_JLE, OP_JMP: begin
                    // range is checked ahead of the condition
                    if ({1'b0, a} >= program_size) begin
                        o.error_code = ERR_RANGE;
                    end else begin
                        case (op)
                            OP_JG:   take = (flag == FLAG_GT);
                            OP_JGE:  take = (flag == FLAG_GT) || (flag == FLAG_EQ);
                            OP_JL:   take = (flag == FLAG_LT);
                            OP_JLE:  take = (flag == FLAG_LT) || (flag == FLAG_EQ);
                            default: take = 1'b1;
                        endcase
                        o.jump_taken  = take;
                        o.jump_target = take ? a : '0;
                    end
                end
                default: ;
            endcase
            o.flag_out = flag;
            pending.push_back(o);
        endfunction

        function void compare_field(string field, logic [DW-1:0] want, logic [DW-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (pending.size() == 0) begin
                $error("result transaction with no instruction outstanding");
                mismatches++;
                return;
            end
            want = pending.pop_front();
            checked++;
            compare_field("result_value", want.result_value, got.result_value);
            compare_field("write_dest",   DW'(want.write_dest), DW'(got.write_dest));
            compare_field("jump_taken",   DW'(want.jump_taken), DW'(got.jump_taken));
            compare_field("jump_target",  want.jump_target,  got.jump_target);
            compare_field("error_code",   DW'(want.error_code), DW'(got.error_code));
            compare_field("flag_out",     DW'(want.flag_out),   DW'(got.flag_out));
            if (want.error_code == ERR_DIV_ZERO) div_zero_seen++;
            if (want.error_code == ERR_RANGE)    range_seen++;
            if (want.jump_taken)                 jumps_taken++;
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [2:0]          paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [OPCODE_W-1:0] i_opcode    = '0;
    logic [DW-1:0]       i_operand_a = '0;
    logic [DW-1:0]       i_operand_b = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DW-1:0]       o_result_value;
    logic                o_write_dest;
    logic                o_jump_taken;
    logic [DW-1:0]       o_jump_target;
    logic [1:0]          o_error_code;
    logic [1:0]          o_flag_out;

    alu_scoreboard sb = new();
    int            cycle_count = 0;
    int            idle_pct    = 0;
    int            stall_pct   = 0;
    int            hold_req    = 0;
    int            hold_left   = 0;
    int            sizes_tried = 1;

    alu_compare_branch_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .o_write_dest   (o_write_dest),
        .o_jump_taken   (o_jump_taken),
        .o_jump_target  (o_jump_target),
        .o_error_code   (o_error_code),
        .o_flag_out     (o_flag_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("alu_compare_branch_unit regression: fail");
        $finish;
    end

    // Receiver: random stalls, or one long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_instruction(i_opcode, i_operand_a, i_operand_b);
            if (o_out_valid && !i_out_stall)
                sb.check_result({o_result_value, o_write_dest, o_jump_taken,
                                 o_jump_target, o_error_code, o_flag_out});
        end
    end

    task automatic apb_access(input logic wr, input logic [31:0] data,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PSIZE_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back_program_size();
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== {23'b0, sb.program_size}) begin
            $error("program_size read: expected %0d, got %0d", sb.program_size, rd);
            sb.mismatches++;
        end
    endtask

    task automatic set_program_size(input logic [PSIZE_W-1:0] value);
        logic [31:0] unused;
        apb_access(1'b1, {23'b0, value}, unused);
        sb.program_size = value;
        sizes_tried++;
        read_back_program_size();
    endtask

    task automatic send_instruction(input logic [OPCODE_W-1:0] op, input logic [DW-1:0] a,
                                    input logic [DW-1:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] pick_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_instruction(output logic [OPCODE_W-1:0] op,
                                      output logic [DW-1:0] a, output logic [DW-1:0] b);
        int unsigned sel;
        int          near;
        sel = $urandom_range(99);
        if (sel < 12)      op = OP_CMP;
        else if (sel < 40) op = 5'($urandom_range(OP_JMP, OP_JG));
        else if (sel < 45) op = 5'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else               op = 5'($urandom_range(OP_SHR, OP_MOV));
        a = pick_value();
        b = pick_value();
        case (op)
            OP_DIV, OP_MOD: if ($urandom_range(5) == 0) b = '0;
            OP_SHL, OP_SHR: if ($urandom_range(3) != 0) b = 8'($urandom_range(DW + 2));
            OP_CMP:         if ($urandom_range(3) == 0) b = a;
            OP_JG, OP_JGE, OP_JL, OP_JLE, OP_JMP: begin
                // aim at the program size boundary
                if ($urandom_range(2) == 0) begin
                    near = int'(sb.program_size) + int'($urandom_range(3)) - 2;
                    a = (near < 0) ? '0 : ((near > 255) ? 8'hFF : 8'(near));
                end
            end
            default: ;
        endcase
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        logic [OPCODE_W-1:0] op;
        logic [DW-1:0]       a;
        logic [DW-1:0]       b;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) begin
            random_instruction(op, a, b);
            send_instruction(op, a, b);
        end
    endtask

    task automatic run_directed();
        send_instruction(OP_MOV, 8'h00, 8'hFF);
        send_instruction(OP_ADD, 8'hFF, 8'h01);
        send_instruction(OP_SUB, 8'h00, 8'h01);
        send_instruction(OP_MUL, 8'hFF, 8'hFF);
        send_instruction(OP_DIV, 8'hFF, 8'h00);
        send_instruction(OP_MOD, 8'h07, 8'h00);
        send_instruction(OP_DIV, 8'hC8, 8'h07);
        send_instruction(OP_MOD, 8'hC8, 8'h07);
        send_instruction(OP_DIV, 8'hFF, 8'hFF);
        send_instruction(OP_AND, 8'hAA, 8'hFF);
        send_instruction(OP_OR,  8'h55, 8'hAA);
        send_instruction(OP_XOR, 8'hFF, 8'h0F);
        send_instruction(OP_SHL, 8'h81, 8'h07);
        send_instruction(OP_SHL, 8'hFF, 8'h08);
        send_instruction(OP_SHR, 8'h80, 8'h07);
        send_instruction(OP_SHR, 8'hFF, 8'hFF);
        // flag still equal from reset
        send_instruction(OP_JG,  8'h0A, 8'h00);
        send_instruction(OP_JGE, 8'h0A, 8'h00);
        send_instruction(OP_CMP, 8'h05, 8'h09);
        send_instruction(OP_JL,  8'hFF, 8'h00);
        send_instruction(OP_JLE, 8'h00, 8'h00);
        send_instruction(OP_CMP, 8'h09, 8'h05);
        send_instruction(OP_JG,  8'h14, 8'h00);
        send_instruction(OP_JMP, 8'hFF, 8'h00);
        send_instruction(OP_UNUSED_LO, 8'hFF, 8'hFF);
        send_instruction(OP_UNUSED_HI, 8'h00, 8'h00);
    endtask

    initial begin
        logic [PSIZE_W-1:0] sizes [8];
        int                 idle_mode  [4];
        int                 stall_mode [4];
        sizes      = '{9'd1, 9'd0, 9'd511, 9'd128, 9'd257, 9'd256, 9'd37, 9'd200};
        idle_mode  = '{0, 62, 0, 13};
        stall_mode = '{0, 0, 62, 13};
        sizes[6]   = 9'($urandom_range(255, 2));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back_program_size();

        run_directed();
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            set_program_size(sizes[p]);
            run_random(160, idle_mode[p % 4], stall_mode[p % 4]);
            wait_drained();
            if (p == 1) begin
                // receiver holds off while the sender keeps offering
                set_program_size(9'd64);
                hold_req = HOLD_CYCLES;
                run_random(40, 0, 0);
                wait_drained();
            end
        end

        if (sb.pending.size() != 0) begin
            $error("%0d results never arrived", sb.pending.size());
            sb.mismatches++;
        end
        $display("checked %0d instructions over %0d program sizes, all opcodes incl. unused",
                 sb.checked, sizes_tried);
        $display("%0d divides by zero, %0d out-of-range jumps, %0d jumps taken",
                 sb.div_zero_seen, sb.range_seen, sb.jumps_taken);
        if (sb.mismatches == 0) begin
            $display("alu_compare_branch_unit regression: pass");
        end else begin
            $display("alu_compare_branch_unit regression: fail");
        end
        $finish;
    end

endmodule
